// ===== rtl/cds_pkg.sv =====
`timescale 1ns / 1ps

package cds_pkg;

    localparam int unsigned ACTION_W = 3;
    localparam int unsigned DAY_W    = 5;
    localparam int unsigned WDAY_W   = 3;
    localparam int unsigned MONTH_W  = 4;
    localparam int unsigned YEAR_W   = 14;
    localparam int unsigned DELTA_W  = 8;

    localparam logic [ACTION_W-1:0] ACT_NEXT_DAY   = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_PREV_DAY   = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_NEXT_MONTH = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_PREV_MONTH = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_NEXT_YEAR  = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_PREV_YEAR  = 3'd5;

    localparam logic [YEAR_W-1:0]  YEAR_MIN  = 14'd1;
    localparam logic [YEAR_W-1:0]  YEAR_MAX  = 14'd9999;
    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
    localparam logic [DAY_W-1:0]   DAY_FIRST = 5'd1;
    localparam logic [DAY_W-1:0]   DAY_MAX   = 5'd31;
    localparam logic [WDAY_W-1:0]  SUNDAY    = 3'd7;

    // Multiplicative inverse of 25 modulo 2**14: y is a multiple of 25 exactly
    // when y * INV25 (mod 2**14) does not exceed DIV25_LIMIT.
    localparam logic [YEAR_W-1:0] INV25       = 14'd7209;
    localparam logic [YEAR_W-1:0] DIV25_LIMIT = 14'd655;

    // A multiple of seven added to every day difference keeps it positive.
    localparam logic [DELTA_W-1:0] WEEK_OFFSET = 8'd70;

    function automatic logic [YEAR_W-1:0] mul_inv25(input logic [YEAR_W-1:0] y);
        logic [2*YEAR_W-1:0] prod;
        prod = (2*YEAR_W)'(y) * (2*YEAR_W)'(INV25);
        return prod[YEAR_W-1:0];
    endfunction

    function automatic logic is_leap(input logic [YEAR_W-1:0] y,
                                     input logic [YEAR_W-1:0] y_inv25);
        logic div25;
        div25 = (y_inv25 <= DIV25_LIMIT);
        // Among multiples of four, a multiple of 100 is a leap year only
        // when it is also a multiple of 16, that is of 400.
        return (y[1:0] == 2'd0) && (!div25 || (y[3:0] == 4'd0));
    endfunction

    function automatic logic [DAY_W-1:0] days_in(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
        logic [DAY_W-1:0] len;
        case (m)
            4'd2:    len = leap ? 5'd29 : 5'd28;
            4'd4:    len = 5'd30;
            4'd6:    len = 5'd30;
            4'd9:    len = 5'd30;
            4'd11:   len = 5'd30;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

    // Residue modulo 7 by folding octal digits, since 8 is 1 modulo 7.
    function automatic logic [WDAY_W-1:0] mod7(input logic [DELTA_W-1:0] x);
        logic [4:0] a;
        logic [3:0] b;
        a = 5'(x[7:6]) + 5'(x[5:3]) + 5'(x[2:0]);
        b = 4'(a[4:3]) + 4'(a[2:0]);
        return (b >= 4'd7) ? 3'(b - 4'd7) : b[2:0];
    endfunction

endpackage

// ===== rtl/cds_in_if.sv =====
`timescale 1ns / 1ps

interface cds_in_if;
    logic                             valid;
    logic                             ready;
    logic [cds_pkg::ACTION_W-1:0]     action;
    logic [cds_pkg::DAY_W-1:0]        day_of_month;
    logic [cds_pkg::WDAY_W-1:0]       weekday;
    logic [cds_pkg::MONTH_W-1:0]      month;
    logic [cds_pkg::YEAR_W-1:0]       year_value;

    modport source (output valid, action, day_of_month, weekday, month, year_value,
                    input ready);
    modport sink (input valid, action, day_of_month, weekday, month, year_value,
                  output ready);
endinterface

// ===== rtl/cds_out_if.sv =====
`timescale 1ns / 1ps

interface cds_out_if;
    logic                             valid;
    logic                             ready;
    logic [cds_pkg::DAY_W-1:0]        new_day_of_month;
    logic [cds_pkg::WDAY_W-1:0]       new_weekday;
    logic [cds_pkg::MONTH_W-1:0]      new_month;
    logic [cds_pkg::YEAR_W-1:0]       new_year;
    logic                             range_flag;

    modport source (output valid, new_day_of_month, new_weekday, new_month, new_year,
                    range_flag, input ready);
    modport sink (input valid, new_day_of_month, new_weekday, new_month, new_year,
                  range_flag, output ready);
endinterface

// ===== rtl/calendar_date_stepper_top.sv =====
`timescale 1ns / 1ps

// Calendar date stepper.
// The date_in channel carries a Gregorian date, its weekday and a step action;
// every transaction on it yields exactly one transaction on date_out with the
// stepped date, its weekday and a flag set when the step would leave years
// 1 to 9999 (the date is then returned unchanged).
// An accepted transaction travels to its result on date_out through
// four register stages: input repair and a divisibility product, the step and
// the target year's product, the day clamp and day difference, and the
// weekday residue in the output register.
// One transaction per cycle unless date_out stalls; each stage holds one item.
// When the receiver holds date_out.ready low, the output register keeps its
// result and the earlier stages go on filling until every stage is occupied;
// only then does date_in.ready fall. Nothing is lost or repeated.
// Reset clears all valid bits, so the pipeline comes out of reset empty and
// date_in.ready high.
module calendar_date_stepper_top
(
    input  logic       clk,
    input  logic       rst_n,
    cds_in_if.sink     date_in,
    cds_out_if.source  date_out
);

    // Per-stage valid bits and advance enables.
    logic [3:0] vld_reg;
    logic [3:0] adv;

    assign adv[3] = !vld_reg[3] || date_out.ready;
    assign adv[2] = !vld_reg[2] || adv[3];
    assign adv[1] = !vld_reg[1] || adv[2];
    assign adv[0] = !vld_reg[0] || adv[1];
    assign date_in.ready = adv[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (adv[0]) vld_reg[0] <= date_in.valid;
            if (adv[1]) vld_reg[1] <= vld_reg[0];
            if (adv[2]) vld_reg[2] <= vld_reg[1];
            if (adv[3]) vld_reg[3] <= vld_reg[2];
        end
    end

    // ---------------------------------------------------------------- stage 1
    logic [cds_pkg::ACTION_W-1:0] s1_act_reg;
    logic [cds_pkg::DAY_W-1:0]    s1_day_reg;
    logic [cds_pkg::WDAY_W-1:0]   s1_wday_reg, s1_wday_next;
    logic [cds_pkg::MONTH_W-1:0]  s1_month_reg, s1_month_next;
    logic [cds_pkg::YEAR_W-1:0]   s1_year_reg, s1_year_next;
    logic [cds_pkg::YEAR_W-1:0]   s1_yinv_reg;

    always_comb
    begin
        if (date_in.month < cds_pkg::MONTH_JAN)
            s1_month_next = cds_pkg::MONTH_JAN;
        else if (date_in.month > cds_pkg::MONTH_DEC)
            s1_month_next = cds_pkg::MONTH_DEC;
        else
            s1_month_next = date_in.month;

        if (date_in.year_value < cds_pkg::YEAR_MIN)
            s1_year_next = cds_pkg::YEAR_MIN;
        else if (date_in.year_value > cds_pkg::YEAR_MAX)
            s1_year_next = cds_pkg::YEAR_MAX;
        else
            s1_year_next = date_in.year_value;

        s1_wday_next = (date_in.weekday == '0) ? cds_pkg::SUNDAY : date_in.weekday;
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            s1_act_reg   <= date_in.action;
            s1_day_reg   <= date_in.day_of_month;
            s1_wday_reg  <= s1_wday_next;
            s1_month_reg <= s1_month_next;
            s1_year_reg  <= s1_year_next;
            s1_yinv_reg  <= cds_pkg::mul_inv25(s1_year_next);
        end
    end

    // ---------------------------------------------------------------- stage 2
    logic                         s2_leap_y;
    logic [cds_pkg::DAY_W-1:0]    s2_len_m;
    logic [cds_pkg::DAY_W-1:0]    s2_day;
    logic [cds_pkg::DAY_W-1:0]    s2_nday_next;
    logic [cds_pkg::MONTH_W-1:0]  s2_nmonth_next;
    logic [cds_pkg::YEAR_W-1:0]   s2_nyear_next;
    logic [cds_pkg::ACTION_W-1:0] s2_act_next;
    logic                         s2_step;
    logic                         s2_flag_next;
    logic                         s2_moved_next;

    logic [cds_pkg::ACTION_W-1:0] s2_act_reg;
    logic [cds_pkg::DAY_W-1:0]    s2_day_reg, s2_nday_reg, s2_len_m_reg;
    logic [cds_pkg::WDAY_W-1:0]   s2_wday_reg;
    logic [cds_pkg::MONTH_W-1:0]  s2_month_reg, s2_nmonth_reg;
    logic [cds_pkg::YEAR_W-1:0]   s2_nyear_reg, s2_nyinv_reg;
    logic                         s2_leap_y_reg, s2_flag_reg, s2_moved_reg;

    always_comb
    begin
        s2_leap_y = cds_pkg::is_leap(s1_year_reg, s1_yinv_reg);
        s2_len_m  = cds_pkg::days_in(s1_month_reg, s2_leap_y);

        if (s1_day_reg < cds_pkg::DAY_FIRST)
            s2_day = cds_pkg::DAY_FIRST;
        else if (s1_day_reg > s2_len_m)
            s2_day = s2_len_m;
        else
            s2_day = s1_day_reg;

        s2_nday_next   = s2_day;
        s2_nmonth_next = s1_month_reg;
        s2_nyear_next  = s1_year_reg;
        s2_step        = 1'b1;

        case (s1_act_reg)
            cds_pkg::ACT_NEXT_DAY:
            begin
                if (s2_day < s2_len_m)
                    s2_nday_next = s2_day + 5'd1;
                else
                begin
                    s2_nday_next = cds_pkg::DAY_FIRST;
                    if (s1_month_reg < cds_pkg::MONTH_DEC)
                        s2_nmonth_next = s1_month_reg + 4'd1;
                    else
                    begin
                        s2_nmonth_next = cds_pkg::MONTH_JAN;
                        s2_nyear_next  = s1_year_reg + 14'd1;
                    end
                end
            end
            cds_pkg::ACT_PREV_DAY:
            begin
                // The last day of the previous month comes from the clamp in
                // the next stage.
                if (s2_day > cds_pkg::DAY_FIRST)
                    s2_nday_next = s2_day - 5'd1;
                else
                begin
                    s2_nday_next = cds_pkg::DAY_MAX;
                    if (s1_month_reg > cds_pkg::MONTH_JAN)
                        s2_nmonth_next = s1_month_reg - 4'd1;
                    else
                    begin
                        s2_nmonth_next = cds_pkg::MONTH_DEC;
                        s2_nyear_next  = s1_year_reg - 14'd1;
                    end
                end
            end
            cds_pkg::ACT_NEXT_MONTH:
            begin
                if (s1_month_reg < cds_pkg::MONTH_DEC)
                    s2_nmonth_next = s1_month_reg + 4'd1;
                else
                begin
                    s2_nmonth_next = cds_pkg::MONTH_JAN;
                    s2_nyear_next  = s1_year_reg + 14'd1;
                end
            end
            cds_pkg::ACT_PREV_MONTH:
            begin
                if (s1_month_reg > cds_pkg::MONTH_JAN)
                    s2_nmonth_next = s1_month_reg - 4'd1;
                else
                begin
                    s2_nmonth_next = cds_pkg::MONTH_DEC;
                    s2_nyear_next  = s1_year_reg - 14'd1;
                end
            end
            cds_pkg::ACT_NEXT_YEAR:
            begin
                s2_nyear_next = s1_year_reg + 14'd1;
            end
            cds_pkg::ACT_PREV_YEAR:
            begin
                s2_nyear_next = s1_year_reg - 14'd1;
            end
            default:
            begin
                s2_step = 1'b0;
            end
        endcase

        s2_flag_next  = s2_step && ((s2_nyear_next < cds_pkg::YEAR_MIN) ||
                                    (s2_nyear_next > cds_pkg::YEAR_MAX));
        s2_moved_next = s2_step && !s2_flag_next;
        s2_act_next   = s1_act_reg;

        if (!s2_moved_next)
        begin
            s2_nday_next   = s2_day;
            s2_nmonth_next = s1_month_reg;
            s2_nyear_next  = s1_year_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            s2_act_reg    <= s2_act_next;
            s2_day_reg    <= s2_day;
            s2_wday_reg   <= s1_wday_reg;
            s2_month_reg  <= s1_month_reg;
            s2_len_m_reg  <= s2_len_m;
            s2_leap_y_reg <= s2_leap_y;
            s2_nday_reg   <= s2_nday_next;
            s2_nmonth_reg <= s2_nmonth_next;
            s2_nyear_reg  <= s2_nyear_next;
            s2_nyinv_reg  <= cds_pkg::mul_inv25(s2_nyear_next);
            s2_flag_reg   <= s2_flag_next;
            s2_moved_reg  <= s2_moved_next;
        end
    end

    // ---------------------------------------------------------------- stage 3
    logic                        s3_leap_ny;
    logic                        s3_cross;
    logic [cds_pkg::DAY_W-1:0]   s3_len_nm;
    logic [cds_pkg::DAY_W-1:0]   s3_nday;
    logic [cds_pkg::DELTA_W-1:0] s3_delta;

    logic [cds_pkg::DAY_W-1:0]   s3_nday_reg;
    logic [cds_pkg::WDAY_W-1:0]  s3_wday_reg;
    logic [cds_pkg::MONTH_W-1:0] s3_nmonth_reg;
    logic [cds_pkg::YEAR_W-1:0]  s3_nyear_reg;
    logic [cds_pkg::DELTA_W-1:0] s3_delta_reg;
    logic                        s3_flag_reg;

    always_comb
    begin
        s3_leap_ny = cds_pkg::is_leap(s2_nyear_reg, s2_nyinv_reg);
        s3_len_nm  = cds_pkg::days_in(s2_nmonth_reg, s3_leap_ny);
        s3_nday    = (s2_nday_reg > s3_len_nm) ? s3_len_nm : s2_nday_reg;
        s3_cross   = 1'b0;
        s3_delta   = cds_pkg::WEEK_OFFSET;

        // Differences are taken modulo 7 later; a year of 365 days counts as 1.
        if (s2_moved_reg)
        begin
            case (s2_act_reg)
                cds_pkg::ACT_NEXT_DAY:
                    s3_delta = cds_pkg::WEEK_OFFSET + 8'd1;
                cds_pkg::ACT_PREV_DAY:
                    s3_delta = cds_pkg::WEEK_OFFSET - 8'd1;
                cds_pkg::ACT_NEXT_MONTH:
                    s3_delta = cds_pkg::WEEK_OFFSET + 8'(s2_len_m_reg) - 8'(s2_day_reg)
                               + 8'(s3_nday);
                cds_pkg::ACT_PREV_MONTH:
                    s3_delta = cds_pkg::WEEK_OFFSET + 8'(s3_nday) - 8'(s2_day_reg)
                               - 8'(s3_len_nm);
                cds_pkg::ACT_NEXT_YEAR:
                begin
                    s3_cross = (s2_month_reg > cds_pkg::MONTH_FEB) ? s3_leap_ny
                                                                   : s2_leap_y_reg;
                    s3_delta = cds_pkg::WEEK_OFFSET + 8'd1 + 8'(s3_cross)
                               + 8'(s3_nday) - 8'(s2_day_reg);
                end
                cds_pkg::ACT_PREV_YEAR:
                begin
                    s3_cross = (s2_month_reg > cds_pkg::MONTH_FEB) ? s2_leap_y_reg
                                                                   : s3_leap_ny;
                    s3_delta = cds_pkg::WEEK_OFFSET - 8'd1 - 8'(s3_cross)
                               + 8'(s3_nday) - 8'(s2_day_reg);
                end
                default:
                    s3_delta = cds_pkg::WEEK_OFFSET;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            s3_nday_reg   <= s3_nday;
            s3_wday_reg   <= s2_wday_reg;
            s3_nmonth_reg <= s2_nmonth_reg;
            s3_nyear_reg  <= s2_nyear_reg;
            s3_delta_reg  <= s3_delta;
            s3_flag_reg   <= s2_flag_reg;
        end
    end

    // ---------------------------------------------------------------- stage 4
    logic [cds_pkg::WDAY_W-1:0] s4_rem;
    logic [3:0]                 s4_sum;
    logic [cds_pkg::WDAY_W-1:0] s4_wday_next;

    logic [cds_pkg::DAY_W-1:0]   out_day_reg;
    logic [cds_pkg::WDAY_W-1:0]  out_wday_reg;
    logic [cds_pkg::MONTH_W-1:0] out_month_reg;
    logic [cds_pkg::YEAR_W-1:0]  out_year_reg;
    logic                        out_flag_reg;

    always_comb
    begin
        s4_rem = cds_pkg::mod7(s3_delta_reg);
        s4_sum = 4'(s3_wday_reg) - 4'd1 + 4'(s4_rem);
        s4_wday_next = (s4_sum >= 4'd7) ? 3'(s4_sum - 4'd6) : 3'(s4_sum + 4'd1);
    end

    always_ff @(posedge clk)
    begin
        if (adv[3])
        begin
            out_day_reg   <= s3_nday_reg;
            out_wday_reg  <= s4_wday_next;
            out_month_reg <= s3_nmonth_reg;
            out_year_reg  <= s3_nyear_reg;
            out_flag_reg  <= s3_flag_reg;
        end
    end

    assign date_out.valid            = vld_reg[3];
    assign date_out.new_day_of_month = out_day_reg;
    assign date_out.new_weekday      = out_wday_reg;
    assign date_out.new_month        = out_month_reg;
    assign date_out.new_year         = out_year_reg;
    assign date_out.range_flag       = out_flag_reg;

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;

    // Actions that the block leaves without effect.
    localparam logic [cds_pkg::ACTION_W-1:0] ACT_SPARE_LO = 3'd6;
    localparam logic [cds_pkg::ACTION_W-1:0] ACT_SPARE_HI = 3'd7;

    localparam int unsigned IDLE_PERCENT   = 12;
    localparam int unsigned REPORT_LIMIT   = 10;
    localparam int unsigned DRAIN_CYCLES   = 12;
    localparam int unsigned LONG_HOLD      = 60;

    typedef struct packed {
        logic [cds_pkg::DAY_W-1:0]   day;
        logic [cds_pkg::WDAY_W-1:0]  wday;
        logic [cds_pkg::MONTH_W-1:0] month;
        logic [cds_pkg::YEAR_W-1:0]  year;
        logic                        out_of_range;
    } stepped_date_t;

    logic clk;
    logic rst_n;

    cds_in_if  date_in_ch ();
    cds_out_if date_out_ch ();

    calendar_date_stepper_top uut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .date_in  (date_in_ch),
        .date_out (date_out_ch)
    );

    stepped_date_t pending_dates[$];
    int unsigned   failure_count;
    bit            sender_idle_en;
    bit            sink_idle_en;
    int unsigned   long_hold_cycles;

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    function automatic bit leap_year(input int unsigned y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic int unsigned month_length(input int unsigned m, input int unsigned y);
        int unsigned len;
        case (m)
            2:       len = leap_year(y) ? 29 : 28;
            4, 6, 9, 11: len = 30;
            default: len = 31;
        endcase
        return len;
    endfunction

    // Day number in the proleptic Gregorian calendar, with 1 January of year 1 as day 1.
    function automatic longint day_count(input int unsigned d, input int unsigned m,
                                         input int unsigned y);
        longint n;
        longint py;
        py = longint'(y) - 1;
        n = py * 365 + py / 4 - py / 100 + py / 400;
        for (int unsigned k = 1; k < m; k++)
        begin
            n += month_length(k, y);
        end
        return n + d;
    endfunction

    function automatic stepped_date_t step_date(
        input logic [cds_pkg::ACTION_W-1:0] act,
        input logic [cds_pkg::DAY_W-1:0]    d_raw,
        input logic [cds_pkg::WDAY_W-1:0]   wd_raw,
        input logic [cds_pkg::MONTH_W-1:0]  m_raw,
        input logic [cds_pkg::YEAR_W-1:0]   y_raw);
        int unsigned   d;
        int unsigned   wd;
        int unsigned   m;
        int unsigned   y;
        int unsigned   nd;
        int unsigned   nm;
        int            ny;
        bit            moved;
        bit            flag;
        longint        r;
        stepped_date_t res;

        m  = 32'((m_raw < cds_pkg::MONTH_JAN) ? cds_pkg::MONTH_JAN :
                 ((m_raw > cds_pkg::MONTH_DEC) ? cds_pkg::MONTH_DEC : m_raw));
        y  = 32'((y_raw < cds_pkg::YEAR_MIN) ? cds_pkg::YEAR_MIN :
                 ((y_raw > cds_pkg::YEAR_MAX) ? cds_pkg::YEAR_MAX : y_raw));
        d  = 32'((d_raw < cds_pkg::DAY_FIRST) ? cds_pkg::DAY_FIRST : d_raw);
        if (d > month_length(m, y))
        begin
            d = month_length(m, y);
        end
        wd = 32'((wd_raw == '0) ? cds_pkg::SUNDAY : wd_raw);

        nd    = d;
        nm    = m;
        ny    = int'(y);
        moved = 1'b1;
        flag  = 1'b0;
        case (act)
            cds_pkg::ACT_NEXT_DAY:
            begin
                if (d < month_length(m, y))
                    nd = d + 1;
                else if (m < cds_pkg::MONTH_DEC)
                begin
                    nd = 1;
                    nm = m + 1;
                end
                else
                begin
                    nd = 1;
                    nm = 32'(cds_pkg::MONTH_JAN);
                    ny = ny + 1;
                end
            end
            cds_pkg::ACT_PREV_DAY:
            begin
                if (d > 1)
                    nd = d - 1;
                else if (m > cds_pkg::MONTH_JAN)
                begin
                    nm = m - 1;
                    nd = month_length(nm, y);
                end
                else
                begin
                    nm = 32'(cds_pkg::MONTH_DEC);
                    nd = 31;
                    ny = ny - 1;
                end
            end
            cds_pkg::ACT_NEXT_MONTH:
            begin
                if (m < cds_pkg::MONTH_DEC)
                    nm = m + 1;
                else
                begin
                    nm = 32'(cds_pkg::MONTH_JAN);
                    ny = ny + 1;
                end
            end
            cds_pkg::ACT_PREV_MONTH:
            begin
                if (m > cds_pkg::MONTH_JAN)
                    nm = m - 1;
                else
                begin
                    nm = 32'(cds_pkg::MONTH_DEC);
                    ny = ny - 1;
                end
            end
            cds_pkg::ACT_NEXT_YEAR: ny = ny + 1;
            cds_pkg::ACT_PREV_YEAR: ny = ny - 1;
            default:                moved = 1'b0;
        endcase

        if (moved && (ny < int'(cds_pkg::YEAR_MIN) || ny > int'(cds_pkg::YEAR_MAX)))
        begin
            flag  = 1'b1;
            moved = 1'b0;
        end

        if (!moved)
        begin
            res.day   = (cds_pkg::DAY_W)'(d);
            res.wday  = (cds_pkg::WDAY_W)'(wd);
            res.month = (cds_pkg::MONTH_W)'(m);
            res.year  = (cds_pkg::YEAR_W)'(y);
        end
        else
        begin
            if (nd > month_length(nm, unsigned'(ny)))
                nd = month_length(nm, unsigned'(ny));
            r = (day_count(nd, nm, unsigned'(ny)) - day_count(d, m, y)) % 7;
            if (r < 0)
                r += 7;
            res.day   = (cds_pkg::DAY_W)'(nd);
            res.wday  = (cds_pkg::WDAY_W)'(((wd - 1) + r) % 7 + 1);
            res.month = (cds_pkg::MONTH_W)'(nm);
            res.year  = (cds_pkg::YEAR_W)'(ny);
        end
        res.out_of_range = flag;
        return res;
    endfunction

    task automatic report_failure(input string what, input stepped_date_t want,
                                  input stepped_date_t got);
        failure_count++;
        if (failure_count <= REPORT_LIMIT)
        begin
            $display("%0t: %s: expected %0d-%0d-%0d wd %0d flag %0d, got %0d-%0d-%0d wd %0d flag %0d",
                     $realtime, what, want.year, want.month, want.day, want.wday,
                     want.out_of_range, got.year, got.month, got.day, got.wday,
                     got.out_of_range);
        end
    endtask

    // Called just after a falling edge; returns just after the falling edge that
    // follows acceptance, with valid left high for a back-to-back transaction.
    task automatic send_date(input logic [cds_pkg::ACTION_W-1:0] act,
                             input logic [cds_pkg::DAY_W-1:0]    d,
                             input logic [cds_pkg::WDAY_W-1:0]   wd,
                             input logic [cds_pkg::MONTH_W-1:0]  m,
                             input logic [cds_pkg::YEAR_W-1:0]   y);
        while (sender_idle_en && $urandom_range(99) < IDLE_PERCENT)
        begin
            date_in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        date_in_ch.valid        <= 1'b1;
        date_in_ch.action       <= act;
        date_in_ch.day_of_month <= d;
        date_in_ch.weekday      <= wd;
        date_in_ch.month        <= m;
        date_in_ch.year_value   <= y;
        do
        begin
            @(posedge clk);
        end
        while (!date_in_ch.ready);
        pending_dates.push_back(step_date(act, d, wd, m, y));
        @(negedge clk);
    endtask

    task automatic send_random_date();
        logic [cds_pkg::ACTION_W-1:0] act;
        logic [cds_pkg::DAY_W-1:0]    d;
        logic [cds_pkg::WDAY_W-1:0]   wd;
        logic [cds_pkg::MONTH_W-1:0]  m;
        logic [cds_pkg::YEAR_W-1:0]   y;
        int unsigned                  pick;

        pick = $urandom_range(99);
        if (pick < 15)
        begin
            // Raw field noise, including out-of-range values and the spare actions.
            act = (cds_pkg::ACTION_W)'($urandom);
            d   = (cds_pkg::DAY_W)'($urandom);
            wd  = (cds_pkg::WDAY_W)'($urandom);
            m   = (cds_pkg::MONTH_W)'($urandom);
            y   = (cds_pkg::YEAR_W)'($urandom);
        end
        else
        begin
            act = (cds_pkg::ACTION_W)'($urandom_range(cds_pkg::ACT_NEXT_DAY,
                                                      cds_pkg::ACT_PREV_YEAR));
            m   = (cds_pkg::MONTH_W)'($urandom_range(cds_pkg::MONTH_JAN, cds_pkg::MONTH_DEC));
            case ($urandom_range(9))
                0:       y = (cds_pkg::YEAR_W)'($urandom_range(1, 3));
                1:       y = (cds_pkg::YEAR_W)'($urandom_range(9997, 9999));
                2:       y = (cds_pkg::YEAR_W)'(100 * $urandom_range(1, 99));
                3:       y = (cds_pkg::YEAR_W)'(4 * $urandom_range(1, 2499));
                default: y = (cds_pkg::YEAR_W)'($urandom_range(1, 9999));
            endcase
            if ($urandom_range(3) == 0)
                d = (cds_pkg::DAY_W)'(month_length(m, y) - $urandom_range(0, 1));
            else
                d = (cds_pkg::DAY_W)'($urandom_range(1, month_length(m, y)));
            wd = (cds_pkg::WDAY_W)'($urandom_range(1, 7));
        end
        send_date(act, d, wd, m, y);
    endtask

    task automatic test_directed_dates();
        send_date(cds_pkg::ACT_NEXT_DAY,   31, 7, 12,  9999);
        send_date(cds_pkg::ACT_PREV_DAY,    1, 1,  1,     1);
        send_date(cds_pkg::ACT_NEXT_DAY,   28, 3,  2,  2024);
        send_date(cds_pkg::ACT_NEXT_DAY,   28, 3,  2,  1900);
        send_date(cds_pkg::ACT_NEXT_DAY,   29, 4,  2,  2000);
        send_date(cds_pkg::ACT_PREV_DAY,    1, 5,  3,  2000);
        send_date(cds_pkg::ACT_NEXT_MONTH, 31, 1,  1,  2023);
        send_date(cds_pkg::ACT_PREV_MONTH, 31, 1,  3,  2024);
        send_date(cds_pkg::ACT_NEXT_MONTH, 15, 2, 12,  2023);
        send_date(cds_pkg::ACT_PREV_MONTH, 10, 2,  1,  2023);
        send_date(cds_pkg::ACT_NEXT_YEAR,  29, 4,  2,  2024);
        send_date(cds_pkg::ACT_PREV_YEAR,  29, 4,  2,  2024);
        send_date(cds_pkg::ACT_NEXT_YEAR,   1, 1,  3,  2023);
        send_date(cds_pkg::ACT_PREV_YEAR,   1, 5,  3,  2024);
        send_date(cds_pkg::ACT_PREV_YEAR,   5, 5,  6,     1);
        send_date(cds_pkg::ACT_NEXT_YEAR,   5, 5,  6,  9999);
        send_date(ACT_SPARE_LO,             0, 0,  0,     0);
        send_date(ACT_SPARE_HI,            31, 7, 15, 16383);
        send_date(cds_pkg::ACT_NEXT_DAY,    0, 0,  0,     0);
        send_date(cds_pkg::ACT_PREV_DAY,   31, 0, 15, 16383);
        send_date(cds_pkg::ACT_NEXT_MONTH, 31, 6, 13, 10000);
        send_date(cds_pkg::ACT_PREV_MONTH, 31, 2,  4,  5000);
        send_date(cds_pkg::ACT_NEXT_DAY,   30, 3,  2,  2023);
        send_date(cds_pkg::ACT_PREV_MONTH,  1, 1,  1,     1);
        send_date(cds_pkg::ACT_NEXT_MONTH, 15, 1, 12,  9999);
    endtask

    task automatic test_random_steps();
        sender_idle_en = 1'b1;
        sink_idle_en   = 1'b1;
        repeat (300)
            send_random_date();
    endtask

    task automatic test_full_rate();
        sender_idle_en = 1'b0;
        sink_idle_en   = 1'b0;
        repeat (100)
            send_random_date();
    endtask

    // The receiver stalls long enough for every stage to fill while items keep coming.
    task automatic test_output_stall();
        // The last transaction is already accepted, so nothing may be offered meanwhile.
        date_in_ch.valid <= 1'b0;
        sender_idle_en = 1'b0;
        sink_idle_en   = 1'b0;
        @(posedge clk);
        long_hold_cycles = LONG_HOLD;
        @(negedge clk);
        repeat (40)
            send_random_date();
        sender_idle_en = 1'b1;
        sink_idle_en   = 1'b1;
        repeat (40)
            send_random_date();
    endtask

    initial
    begin
        date_out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (long_hold_cycles > 0)
            begin
                date_out_ch.ready <= 1'b0;
                long_hold_cycles--;
            end
            else if (sink_idle_en && $urandom_range(99) < IDLE_PERCENT)
                date_out_ch.ready <= 1'b0;
            else
                date_out_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : check_results
        stepped_date_t got;
        stepped_date_t want;
        if (rst_n && date_out_ch.valid && date_out_ch.ready)
        begin
            got.day          = date_out_ch.new_day_of_month;
            got.wday         = date_out_ch.new_weekday;
            got.month        = date_out_ch.new_month;
            got.year         = date_out_ch.new_year;
            got.out_of_range = date_out_ch.range_flag;
            if (pending_dates.size() == 0)
                report_failure("unexpected transaction", '0, got);
            else
            begin
                want = pending_dates.pop_front();
                if (got.day !== want.day || got.wday !== want.wday ||
                    got.month !== want.month || got.year !== want.year ||
                    got.out_of_range !== want.out_of_range)
                    report_failure("mismatch", want, got);
            end
        end
    end

    initial
    begin
        #400000;
        $display("calendar_date_stepper_top regression: fail");
        $finish;
    end

    initial
    begin
        rst_n                   = 1'b0;
        failure_count           = 0;
        sender_idle_en          = 1'b1;
        sink_idle_en            = 1'b1;
        long_hold_cycles        = 0;
        date_in_ch.valid        = 1'b0;
        date_in_ch.action       = '0;
        date_in_ch.day_of_month = '0;
        date_in_ch.weekday      = '0;
        date_in_ch.month        = '0;
        date_in_ch.year_value   = '0;
        repeat (9)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed_dates();
        test_random_steps();
        test_full_rate();
        test_output_stall();

        date_in_ch.valid <= 1'b0;
        sink_idle_en = 1'b0;
        while (pending_dates.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        if (failure_count == 0 && pending_dates.size() == 0)
            $display("calendar_date_stepper_top regression: pass");
        else
            $display("calendar_date_stepper_top regression: fail");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/cds_pkg.sv
rtl/cds_in_if.sv
rtl/cds_out_if.sv
rtl/calendar_date_stepper_top.sv
tb/tb.sv
